@@ src/qoi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qoi_pkg
// Shared types and constants of the QOI image encoder.
// ----------------------------------------------------------------------------
package qoi_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int unsigned RUN_LIMIT     = 62;

  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hC0;
  localparam logic [7:0] OP_RGB   = 8'hFE;
  localparam logic [7:0] OP_RGBA  = 8'hFF;

  localparam logic [7:0]  END_LAST_BYTE = 8'h01;
  localparam logic [7:0]  END_PAD_BYTE  = 8'h00;
  localparam logic [3:0]  END_LEN       = 4'd8;

  localparam logic [2:0]  CH_RGB  = 3'd3;
  localparam logic [2:0]  CH_RGBA = 3'd4;

  localparam logic [31:0] PREV_RESET = 32'h0000_00FF;

  localparam int unsigned OP_BYTES = 6;  // run flush plus the longest literal

  // Bytes one pixel causes, handed to the output serializer.
  typedef struct packed {
    logic [OP_BYTES-1:0][7:0] bytes;
    logic [2:0]               cnt;
    logic                     fin;   // append end marker
  } qoi_desc_t;

  function automatic logic [SLOT_W-1:0] qoi_hash(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b, input logic [7:0] a);
    logic [SLOT_W-1:0] h;
    h = SLOT_W'(r[SLOT_W-1:0] * SLOT_W'(3)) + SLOT_W'(g[SLOT_W-1:0] * SLOT_W'(5))
      + SLOT_W'(b[SLOT_W-1:0] * SLOT_W'(7)) + SLOT_W'(a[SLOT_W-1:0] * SLOT_W'(11));
    return h;
  endfunction

endpackage

@@ src/qoi_ser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qoi_ser
// Output register and byte serializer: one descriptor, one byte per beat.
// ----------------------------------------------------------------------------
module qoi_ser
  import qoi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  qoi_desc_t push_desc_i,
  output logic      m_axis_tvalid_o,
  input  logic      m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // code_byte
  output logic      m_axis_tlast_o,    // end_of_image
  output logic [0:0] m_axis_tuser_o    // [0] last_of_item
);

  logic      dv_q;
  qoi_desc_t desc_q;
  logic [3:0] idx_q;
  logic [3:0] total;
  logic       last;
  logic       beat;

  assign total = {1'b0, desc_q.cnt} + (desc_q.fin ? END_LEN : 4'd0);
  assign last  = (idx_q == total - 4'd1);
  assign beat  = dv_q && m_axis_tready_i;

  assign push_ready_o = !dv_q || (beat && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q  <= 1'b0;
      idx_q <= '0;
    end else if (push_valid_i && push_ready_o) begin
      dv_q  <= 1'b1;
      idx_q <= '0;
    end else if (beat) begin
      idx_q <= idx_q + 4'd1;
      if (last) dv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i && push_ready_o) desc_q <= push_desc_i;
  end

  always_comb begin
    if (idx_q < {1'b0, desc_q.cnt}) m_axis_tdata_o = desc_q.bytes[idx_q[2:0]];
    else if (last)                  m_axis_tdata_o = END_LAST_BYTE;
    else                            m_axis_tdata_o = END_PAD_BYTE;
  end

  assign m_axis_tvalid_o   = dv_q;
  assign m_axis_tlast_o    = desc_q.fin && last;
  assign m_axis_tuser_o[0] = last;

endmodule

@@ src/qoi_image_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qoi_image_encoder
// QOI chunk encoder: pixels in raster order in, encoded byte stream out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per beat (tdata = R,G,B,A from bit 0 up) with
//   tlast marking the final pixel of the image. m_axis carries one code byte
//   per beat; tuser[0] flags the last byte a pixel caused, tlast flags the
//   closing byte of the 8-byte end marker. cfg_* writes channel_count
//   (4 = RGBA, anything else = RGB with alpha forced to 255); write it only
//   while the block is idle.
//   Pipeline: the pixel is hashed and the index table read on acceptance,
//   the op is chosen in the next cycle, and its bytes go out from the output
//   register of the serializer, one byte per beat.
//   Throughput: one pixel per cycle while each pixel yields at most one byte
//   and m_axis is ready; a pixel yielding more bytes holds the serializer
//   until its last byte is out (up to 14 bytes with run flush and end marker).
//   Pixels only extending a run give no output. The table memory is read and
//   written once a cycle, with a forward path for a write to the slot just read.
//   Reset (and every final pixel) clears the table through per-entry valid
//   bits at once, so no clearing pass is needed. If m_axis stalls, the output
//   register holds and the input stops once the stage in front of it is full.
// ----------------------------------------------------------------------------
module qoi_image_encoder
  import qoi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,       // channel_count
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // red, green, blue, alpha
  input  logic        s_axis_tlast_i,   // final_pixel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // code_byte
  output logic        m_axis_tlast_o,   // end_of_image
  output logic [0:0]  m_axis_tuser_o    // [0] last_of_item
);

  // configuration
  logic [2:0] chan_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) chan_q <= CH_RGB;
    else if (cfg_valid_i) chan_q <= cfg_data_i;
  end

  // stage 0: hash and table read
  logic              in_fire;
  logic [7:0]        a0;
  logic [31:0]       px0;
  logic [SLOT_W-1:0] slot0;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign a0      = (chan_q == CH_RGBA) ? s_axis_tdata_i[31:24] : 8'hFF;
  assign px0     = {s_axis_tdata_i[7:0], s_axis_tdata_i[15:8], s_axis_tdata_i[23:16], a0};
  assign slot0   = qoi_hash(s_axis_tdata_i[7:0], s_axis_tdata_i[15:8],
                            s_axis_tdata_i[23:16], a0);

  logic [31:0]        mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_q;
  logic [31:0]        rd_px_q;
  logic               rd_vld_q;
  logic               fwd_q;
  logic [31:0]        fwd_px_q;
  logic               clr_q;

  // stage 1 registers
  logic              s1_vld_q;
  logic [31:0]       s1_px_q;
  logic              s1_fin_q;
  logic [SLOT_W-1:0] s1_slot_q;

  logic [31:0] prev_q, prev_d;
  logic        run_act_q, run_act_d;
  logic [5:0]  run_len_q, run_len_d;

  logic        s1_fire;
  logic        we;
  logic        push_valid, push_ready;
  qoi_desc_t   desc;

  assign s_axis_tready_o = !s1_vld_q || s1_fire;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[s1_slot_q] <= s1_px_q;
    if (in_fire) rd_px_q <= mem_q[slot0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (s1_fire && s1_fin_q) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[s1_slot_q] <= 1'b1;
    end
  end

  // read-during-write and clear forwarding for the pixel entering stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
      clr_q    <= 1'b0;
    end else if (in_fire) begin
      rd_vld_q <= vld_q[slot0];
      fwd_q    <= we && (s1_slot_q == slot0);
      clr_q    <= s1_fire && s1_fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fwd_px_q  <= s1_px_q;
      s1_px_q   <= px0;
      s1_fin_q  <= s_axis_tlast_i;
      s1_slot_q <= slot0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      prev_q    <= PREV_RESET;
      run_act_q <= 1'b0;
      run_len_q <= '0;
    end else begin
      if (in_fire) s1_vld_q <= 1'b1;
      else if (s1_fire) s1_vld_q <= 1'b0;
      if (s1_fire) begin
        prev_q    <= prev_d;
        run_act_q <= run_act_d;
        run_len_q <= run_len_d;
      end
    end
  end

  // stage 1: op selection
  logic [31:0]       entry;
  logic              hit, same;
  logic [7:0]        r1, g1, b1, a1, pr, pg, pb, pa;
  logic signed [7:0] dr, dg, db;
  logic signed [8:0] drg, dbg;
  logic              diff_ok, luma_ok;
  logic [5:0]        nlen;
  logic              fl;
  logic [7:0]        fb;
  logic [OP_BYTES-1:0][7:0] ob;
  logic [2:0]        ocnt;

  assign entry = clr_q ? 32'h0 : (fwd_q ? fwd_px_q : (rd_vld_q ? rd_px_q : 32'h0));
  assign hit   = (entry == s1_px_q);
  assign same  = (s1_px_q == prev_q);

  assign {r1, g1, b1, a1} = s1_px_q;
  assign {pr, pg, pb, pa} = prev_q;
  assign dr  = r1 - pr;
  assign dg  = g1 - pg;
  assign db  = b1 - pb;
  assign drg = {dr[7], dr} - {dg[7], dg};
  assign dbg = {db[7], db} - {dg[7], dg};
  assign diff_ok = (dr >= -8'sd2) && (dr <= 8'sd1) && (dg >= -8'sd2) && (dg <= 8'sd1)
                && (db >= -8'sd2) && (db <= 8'sd1);
  assign luma_ok = (dg >= -8'sd32) && (dg <= 8'sd31) && (drg >= -9'sd8) && (drg <= 9'sd7)
                && (dbg >= -9'sd8) && (dbg <= 9'sd7);
  assign nlen = run_act_q ? run_len_q + 6'd1 : 6'd0;

  always_comb begin
    run_act_d = run_act_q;
    run_len_d = run_len_q;
    fl        = 1'b0;
    fb        = OP_RUN;
    ob        = '0;
    ocnt      = 3'd0;
    we        = 1'b0;
    if (same) begin
      run_act_d = 1'b1;
      run_len_d = nlen;
      if ({1'b0, nlen} + 7'd1 >= 7'(RUN_LIMIT)) begin
        fl        = 1'b1;
        fb        = OP_RUN | {2'b00, nlen};
        run_act_d = 1'b0;
        run_len_d = '0;
      end
    end else begin
      if (run_act_q) begin
        fl        = 1'b1;
        fb        = OP_RUN | {2'b00, run_len_q};
        run_act_d = 1'b0;
        run_len_d = '0;
      end
      if (hit) begin
        ob[0] = OP_INDEX | 8'(s1_slot_q);
        ocnt  = 3'd1;
      end else begin
        we = s1_fire;
        if (a1 == pa) begin
          if (diff_ok) begin
            ob[0] = OP_DIFF | {2'b00, 2'(dr[1:0] + 2'd2), 2'(dg[1:0] + 2'd2),
                               2'(db[1:0] + 2'd2)};
            ocnt  = 3'd1;
          end else if (luma_ok) begin
            ob[0] = OP_LUMA | {2'b00, 6'(dg[5:0] + 6'd32)};
            ob[1] = {4'(drg[3:0] + 4'd8), 4'(dbg[3:0] + 4'd8)};
            ocnt  = 3'd2;
          end else begin
            ob[0] = OP_RGB;
            ob[1] = r1;
            ob[2] = g1;
            ob[3] = b1;
            ocnt  = 3'd4;
          end
        end else begin
          ob[0] = OP_RGBA;
          ob[1] = r1;
          ob[2] = g1;
          ob[3] = b1;
          ob[4] = a1;
          ocnt  = 3'd5;
        end
      end
    end
    // final pixel flushes a pending run; only a run that was just extended can be left
    if (s1_fin_q) begin
      if (run_act_d) begin
        fl = 1'b1;
        fb = OP_RUN | {2'b00, run_len_d};
      end
      run_act_d = 1'b0;
      run_len_d = '0;
    end
  end

  assign prev_d = s1_fin_q ? PREV_RESET : s1_px_q;

  always_comb begin
    desc.fin      = s1_fin_q;
    desc.cnt      = ocnt + {2'b00, fl};
    desc.bytes[0] = fl ? fb : ob[0];
    for (int i = 1; i < OP_BYTES; i++) begin
      desc.bytes[i] = fl ? ob[i-1] : ob[i];
    end
  end

  assign push_valid = s1_vld_q && ((desc.cnt != 3'd0) || s1_fin_q);
  assign s1_fire    = s1_vld_q && (!push_valid || push_ready);

  qoi_ser u_ser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_valid_i   (push_valid),
    .push_ready_o   (push_ready),
    .push_desc_i    (desc),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

endmodule

@@ src/qoi_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qoi_chk
// Port-level checks of the QOI encoder output stream.
// ----------------------------------------------------------------------------
module qoi_chk
  import qoi_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic [0:0] m_axis_tuser_o
);

  // closing marker byte is also the last byte of its pixel
  a_eoi_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o[0])
    else $error("end_of_image without last_of_item");

  a_eoi_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o == END_LAST_BYTE)
    else $error("end marker does not close with 0x01");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output byte changed while stalled");

endmodule

bind qoi_image_encoder qoi_chk u_qoi_chk (.*);
